// ===== rtl/drd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants of the drag-release debounce filter.
// ----------------------------------------------------------------------------
package drd_pkg;

    // Request codes carried in the input tuser
    localparam logic [1:0] REQ_PRESS   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // Delivered event kinds
    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'd4;

    // Controller states
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_PROC     = 6'b000010,
        ST_SCAN     = 6'b000100,
        ST_SCAN_END = 6'b001000,
        ST_EMIT_RD  = 6'b010000,
        ST_EMIT_OUT = 6'b100000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch an accepted input transaction
        logic clr_slot;     // cancel the pending release of the button
        logic wr_pend;      // store a held-back release
        logic load_single;  // deliver the captured press or release
        logic scan_start;   // clear expiry mask, rewind scan index
        logic scan_run;     // read one pending entry for the expiry check
        logic emit_rd;      // read the lowest expired entry
        logic load_emit;    // deliver the entry read by emit_rd
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       in_range;
        logic       slot_valid;
        logic       emulated;
        logic       hold;       // release ends a drag and debounce is enabled
        logic       out_free;
        logic       scan_last;
        logic       mask_any;
    } t_status;

endpackage

// ===== rtl/drd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_ctrl
// Sequencer: decides each request and steps the tick scan and delivery.
// ----------------------------------------------------------------------------
module drd_ctrl
    import drd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PROC;
                end
            end
            ST_PROC: begin
                case (i_status.req_type)
                    REQ_PRESS: begin
                        if (i_status.in_range && i_status.slot_valid) begin
                            o_cmd.clr_slot = 1'b1;
                            n_state        = ST_IDLE;
                        end else if (i_status.emulated) begin
                            n_state = ST_IDLE;
                        end else if (i_status.out_free) begin
                            o_cmd.load_single = 1'b1;
                            n_state           = ST_IDLE;
                        end
                    end
                    REQ_RELEASE: begin
                        if (i_status.emulated) begin
                            n_state = ST_IDLE;
                        end else if (i_status.hold) begin
                            o_cmd.wr_pend = 1'b1;
                            n_state       = ST_IDLE;
                        end else if (i_status.out_free) begin
                            o_cmd.load_single = 1'b1;
                            n_state           = ST_IDLE;
                        end
                    end
                    REQ_TICK: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                // check stage finishes the last entry
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                if (i_status.mask_any) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = ST_EMIT_OUT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_emit = 1'b1;
                    n_state         = ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/drd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_datapath
// Input capture, config, pending store, expiry check and output register.
// ----------------------------------------------------------------------------
module drd_datapath
    import drd_pkg::*;
#(
    parameter int BUTTON_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input transaction
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_button,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic        i_is_emulated,
    input  logic        i_held_pressed,
    input  logic [15:0] i_drag_movement,
    input  logic [31:0] i_now_ms,
    // control
    input  t_cmd        i_cmd,
    output t_status     o_status,
    // output register
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_event_kind,
    output logic [7:0]  o_event_button,
    output logic [15:0] o_event_x,
    output logic [15:0] o_event_y,
    output logic        o_last
);

    localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(BUTTON_COUNT - 1);
    localparam logic [7:0] BTN_MAX = 8'(BUTTON_COUNT);

    // configuration registers
    logic [15:0] r_debounce_ms;
    logic [15:0] r_drag_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= '0;
            r_drag_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:  r_debounce_ms    <= i_cfg_data;
                CFG_THRESHOLD: r_drag_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0]  r_req_type;
    logic [7:0]  r_button;
    logic [15:0] r_pos_x;
    logic [15:0] r_pos_y;
    logic        r_emulated;
    logic        r_pressed;
    logic [15:0] r_movement;
    logic [31:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_button   <= i_button;
            r_pos_x    <= i_pos_x;
            r_pos_y    <= i_pos_y;
            r_emulated <= i_is_emulated;
            r_pressed  <= i_held_pressed;
            r_movement <= i_drag_movement;
            r_now      <= i_now_ms;
        end
    end

    // request decode
    logic          in_range;
    logic [IW-1:0] slot;
    logic          ends_drag;

    assign in_range  = (r_button != 8'd0) && (r_button <= BTN_MAX);
    assign slot      = IW'(r_button - 8'd1);
    assign ends_drag = in_range && r_pressed && (r_movement > r_drag_threshold);

    // pending store: valid flags in flops, payload {deadline, y, x} in memory
    logic [BUTTON_COUNT-1:0] r_valid;
    logic [63:0]             r_mem [BUTTON_COUNT];
    logic [63:0]             r_rd_data;
    logic [IW-1:0]           rd_addr;
    logic                    rd_en;

    // scan and delivery bookkeeping
    logic [IW-1:0]           r_scan_idx;
    logic                    r_chk_vld;
    logic [IW-1:0]           r_chk_idx;
    logic [BUTTON_COUNT-1:0] r_mask;
    logic [IW-1:0]           r_emit_idx;
    logic [IW-1:0]           low_idx;
    logic [31:0]             diff;
    logic                    expired;

    assign rd_en   = i_cmd.scan_run | i_cmd.emit_rd;
    assign rd_addr = i_cmd.scan_run ? r_scan_idx : low_idx;
    assign diff    = r_now - r_rd_data[63:32];
    assign expired = r_chk_vld && r_valid[r_chk_idx] && !diff[31];

    // lowest expired entry
    always_comb begin
        low_idx = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = IW'(i);
            end
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pend) begin
            r_mem[slot] <= {r_now + {16'd0, r_debounce_ms}, r_pos_y, r_pos_x};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.wr_pend) begin
                r_valid[slot] <= 1'b1;
            end
            if (i_cmd.clr_slot) begin
                r_valid[slot] <= 1'b0;
            end
            if (expired) begin
                r_valid[r_chk_idx] <= 1'b0;
            end
        end
    end

    // scan counter, check stage and expiry mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
            r_mask    <= '0;
        end else begin
            r_chk_vld <= i_cmd.scan_run;
            if (i_cmd.scan_start) begin
                r_mask <= '0;
            end else begin
                if (expired) begin
                    r_mask[r_chk_idx] <= 1'b1;
                end
                if (i_cmd.emit_rd) begin
                    r_mask[low_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_run && (r_scan_idx != LAST_IDX)) begin
            r_scan_idx <= r_scan_idx + IW'(1);
        end
        r_chk_idx <= r_scan_idx;
        if (i_cmd.emit_rd) begin
            r_emit_idx <= low_idx;
        end
    end

    // output register
    logic r_out_vld;
    logic out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    logic        r_out_kind;
    logic [7:0]  r_out_button;
    logic [15:0] r_out_x;
    logic [15:0] r_out_y;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_out_kind   <= (r_req_type == REQ_RELEASE) ? KIND_RELEASE : KIND_PRESS;
            r_out_button <= r_button;
            r_out_x      <= r_pos_x;
            r_out_y      <= r_pos_y;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_emit) begin
            r_out_kind   <= KIND_RELEASE;
            r_out_button <= 8'(r_emit_idx) + 8'd1;
            r_out_x      <= r_rd_data[15:0];
            r_out_y      <= r_rd_data[31:16];
            r_out_last   <= ~|r_mask;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_kind   = r_out_kind;
    assign o_event_button = r_out_button;
    assign o_event_x      = r_out_x;
    assign o_event_y      = r_out_y;
    assign o_last         = r_out_last;

    // status to controller
    assign o_status.req_type   = r_req_type;
    assign o_status.in_range   = in_range;
    assign o_status.slot_valid = r_valid[slot];
    assign o_status.emulated   = r_emulated;
    assign o_status.hold       = ends_drag && (r_debounce_ms != 16'd0);
    assign o_status.out_free   = out_free;
    assign o_status.scan_last  = (r_scan_idx == LAST_IDX);
    assign o_status.mask_any   = |r_mask;

endmodule

// ===== rtl/drag_release_debounce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drag_release_debounce_core
// Mouse button event filter holding back drag-ending releases for a window.
// ----------------------------------------------------------------------------
// Press/release: accepted in one cycle, decided the next; the result is loaded
//   into the output register once that is free, and a new request is accepted
//   only after the previous one is decided.
// Tick: the pending store is scanned one entry a cycle through its read port,
//   then each expired release is read and delivered, lowest button first.
// Reset (i_rst_n low, synchronous): clears pending flags, state and output
//   valid; debounce_ms to 0, drag_threshold to 4. No clearing pass.
module drag_release_debounce_core
    import drd_pkg::*;
#(
    parameter int BUTTON_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] button, [23:8] pos_x, [39:24] pos_y, [40] is_emulated,
    // [41] held_pressed, [57:42] drag_movement, [89:58] now_ms, [95:90] zero
    input  logic [95:0] i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_tuser,
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] event_button, [23:8] event_x, [39:24] event_y
    output logic [39:0] o_m_tdata,
    // [0] event_kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    t_cmd    cmd;
    t_status status;

    logic [7:0]  ev_button;
    logic [15:0] ev_x;
    logic [15:0] ev_y;

    // sequencer
    drd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    drd_datapath #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_s_tuser),
        .i_button        (i_s_tdata[7:0]),
        .i_pos_x         (i_s_tdata[23:8]),
        .i_pos_y         (i_s_tdata[39:24]),
        .i_is_emulated   (i_s_tdata[40]),
        .i_held_pressed  (i_s_tdata[41]),
        .i_drag_movement (i_s_tdata[57:42]),
        .i_now_ms        (i_s_tdata[89:58]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_event_kind    (o_m_tuser),
        .o_event_button  (ev_button),
        .o_event_x       (ev_x),
        .o_event_y       (ev_y),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {ev_y, ev_x, ev_button};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the drag-release debounce filter. A queue of button
// requests feeds a stream driver; every accepted transaction runs through a
// local model of the pending-release store that queues the events the block
// must deliver. A monitor checks each delivered event against the oldest
// queued one. Directed cases come first, then randomized drag sequences,
// cancels, ticks and noise under several debounce and threshold settings,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import drd_pkg::*;

    localparam int BUTTON_COUNT  = 10;
    localparam int SETTLE_CYCLES = 4 * (BUTTON_COUNT + 3);
    localparam int MAX_REPORTS   = 10;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         button;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               is_emulated;
        logic               held_pressed;
        logic [15:0]        drag_movement;
        logic [31:0]        now_ms;
    } t_btn_req;

    typedef struct packed {
        logic               kind;
        logic [7:0]         button;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_btn_event;

    // DUT inputs, all driven to known values from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic        cfg_idx  = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    drag_release_debounce_core #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast)
    );

    // Clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state: configuration and pending-release store
    logic [15:0] debounce_window = '0;
    logic [15:0] drag_limit      = THRESHOLD_RESET;
    logic        held_valid    [0:BUTTON_COUNT-1];
    logic [15:0] held_x        [0:BUTTON_COUNT-1];
    logic [15:0] held_y        [0:BUTTON_COUNT-1];
    logic [31:0] held_deadline [0:BUTTON_COUNT-1];

    t_btn_req   pending_reqs[$];
    t_btn_event expected_events[$];
    t_btn_req   s_item = '0;
    t_btn_req   next_req;
    t_btn_event seen_event;
    t_btn_event want_event;
    int         errors = 0;
    logic       calm = 1'b0;
    logic [31:0] clock_ms = '0;

    // Works out the events one accepted request delivers, updating the store
    function automatic void predict_events(input t_btn_req r);
        logic       in_range;
        int         slot;
        int         last_i;
        logic [31:0] diff;
        in_range = (r.button >= 8'd1) && (r.button <= BUTTON_COUNT);
        slot     = in_range ? int'(r.button) - 1 : 0;
        case (r.req_type)
            REQ_PRESS: begin
                if (in_range && held_valid[slot]) begin
                    held_valid[slot] = 1'b0;
                end else if (!r.is_emulated) begin
                    expected_events.push_back({KIND_PRESS, r.button, r.pos_x, r.pos_y, 1'b1});
                end
            end
            REQ_RELEASE: begin
                if (!r.is_emulated) begin
                    if (in_range && r.held_pressed && r.drag_movement > drag_limit &&
                        debounce_window != 16'd0) begin
                        held_valid[slot]    = 1'b1;
                        held_x[slot]        = r.pos_x;
                        held_y[slot]        = r.pos_y;
                        held_deadline[slot] = r.now_ms + 32'(debounce_window);
                    end else begin
                        expected_events.push_back(
                            {KIND_RELEASE, r.button, r.pos_x, r.pos_y, 1'b1});
                    end
                end
            end
            REQ_TICK: begin
                // find the highest expired entry first so it carries last
                last_i = -1;
                for (int i = 0; i < BUTTON_COUNT; i++) begin
                    diff = r.now_ms - held_deadline[i];
                    if (held_valid[i] && !diff[31]) last_i = i;
                end
                for (int i = 0; i < BUTTON_COUNT; i++) begin
                    diff = r.now_ms - held_deadline[i];
                    if (held_valid[i] && !diff[31]) begin
                        held_valid[i] = 1'b0;
                        expected_events.push_back({KIND_RELEASE, 8'(i + 1), held_x[i],
                                                   held_y[i], i == last_i});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Request driver: holds tdata stable until the transaction completes
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_events(s_item);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                    next_req = pending_reqs.pop_front();
                    s_item   <= next_req;
                    s_tuser  <= next_req.req_type;
                    s_tdata  <= {6'd0, next_req.now_ms, next_req.drag_movement,
                                 next_req.held_pressed, next_req.is_emulated,
                                 next_req.pos_y, next_req.pos_x, next_req.button};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Event sink back-pressure
    always @(posedge clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    task automatic log_mismatch(input string what, input t_btn_event want,
                                input t_btn_event got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display({"%0t: %s: expected kind %0d btn %0d x %0d y %0d last %0d, ",
                      "got kind %0d btn %0d x %0d y %0d last %0d"},
                     $realtime, what, want.kind, want.button, want.x, want.y, want.last,
                     got.kind, got.button, got.x, got.y, got.last);
    endtask

    // Event monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            seen_event = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24], m_tlast};
            if (expected_events.size() == 0) begin
                log_mismatch("unexpected event", '0, seen_event);
            end else begin
                want_event = expected_events.pop_front();
                if (seen_event.kind != want_event.kind ||
                    seen_event.button != want_event.button ||
                    seen_event.x != want_event.x || seen_event.y != want_event.y ||
                    seen_event.last != want_event.last)
                    log_mismatch("event mismatch", want_event, seen_event);
            end
        end
    end

    task automatic push_req(input logic [1:0] kind, input logic [7:0] btn,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic emu, input logic held,
                            input logic [15:0] mov, input logic [31:0] now);
        pending_reqs.push_back({kind, btn, x, y, emu, held, mov, now});
    endtask

    // Register writes happen only with the block idle
    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEBOUNCE) debounce_window = val;
        else drag_limit = val;
    endtask

    // Wait for all requests to go out and all events to come back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic: mostly press/drag-release pairs and ticks, some noise
    task automatic random_phase(input int n_items, input logic [31:0] start_ms);
        int          made;
        int          pick;
        int          step_max;
        logic [7:0]  btn;
        logic [15:0] mov;
        logic [1:0]  kind;
        made     = 0;
        clock_ms = start_ms;
        step_max = int'(debounce_window) / 4 + 3;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            btn  = 8'($urandom_range(1, BUTTON_COUNT));
            if (pick < 45) begin
                push_req(REQ_PRESS, btn, 16'($urandom), 16'($urandom),
                         $urandom_range(0, 9) == 0, 1'($urandom), 16'($urandom), clock_ms);
                clock_ms += $urandom_range(0, step_max);
                mov = (drag_limit == 16'hFFFF) ? 16'hFFFF
                    : 16'($urandom_range(32'(drag_limit) + 1, 65535));
                push_req(REQ_RELEASE, btn, 16'($urandom), 16'($urandom),
                         $urandom_range(0, 11) == 0, $urandom_range(0, 9) != 0, mov,
                         clock_ms);
                made += 2;
            end else if (pick < 60) begin
                // a press that may cancel a pending release
                push_req(REQ_PRESS, btn, 16'($urandom), 16'($urandom), 1'($urandom),
                         1'($urandom), 16'($urandom), clock_ms);
                made++;
            end else if (pick < 82) begin
                push_req(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom), clock_ms);
                made++;
            end else begin
                kind = 2'($urandom_range(0, 3));
                push_req(kind, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                         1'($urandom), 16'($urandom),
                         $urandom_range(0, 1) ? clock_ms : $urandom);
                if (kind != REQ_UNUSED) made++;
            end
            if ($urandom_range(0, 99) < 3) clock_ms += $urandom;
            else clock_ms += $urandom_range(0, step_max);
        end
    endtask

    // Stimulus sequence
    initial begin
        logic [31:0] t0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            held_valid[i]    = 1'b0;
            held_x[i]        = '0;
            held_y[i]        = '0;
            held_deadline[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no debounce, so no release is held back
        push_req(REQ_PRESS,   8'd1,   16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 32'h0);
        push_req(REQ_RELEASE, 8'd1,   16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
        push_req(REQ_PRESS,   8'd255, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 32'h0);
        push_req(REQ_RELEASE, 8'd0,   16'h1234, 16'h5678, 1'b0, 1'b1, 16'hFFFF, 32'h0);
        push_req(REQ_PRESS,   8'd2,   16'h0011, 16'h0022, 1'b1, 1'b0, 16'h0000, 32'h0);
        push_req(REQ_RELEASE, 8'd2,   16'h0011, 16'h0022, 1'b1, 1'b1, 16'hFFFF, 32'h0);
        push_req(REQ_UNUSED,  8'd3,   16'h0033, 16'h0044, 1'b0, 1'b1, 16'hFFFF, 32'h0);
        push_req(REQ_TICK,    8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 32'h10);
        wait_drained();

        // 20 ms window, time base just below the wrap point
        write_reg(CFG_DEBOUNCE, 16'd20);
        t0 = 32'hFFFF_FFF0;
        push_req(REQ_RELEASE, 8'd3,  16'h0100, 16'h0200, 1'b0, 1'b1, 16'd5,    t0);
        push_req(REQ_RELEASE, 8'd3,  16'h0101, 16'h0201, 1'b0, 1'b1, 16'd4,    t0);
        push_req(REQ_RELEASE, 8'd3,  16'h0102, 16'h0202, 1'b0, 1'b0, 16'hFFFF, t0);
        push_req(REQ_RELEASE, 8'd11, 16'h0103, 16'h0203, 1'b0, 1'b1, 16'hFFFF, t0);
        push_req(REQ_RELEASE, 8'd10, 16'hF000, 16'h0FFF, 1'b0, 1'b1, 16'hFFFF, t0 + 2);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, t0 + 19);
        // release over a pending one moves its deadline
        push_req(REQ_RELEASE, 8'd3,  16'hABCD, 16'h4321, 1'b0, 1'b1, 16'd6,    t0 + 5);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, t0 + 22);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, t0 + 25);
        // emulated press still cancels a pending release
        push_req(REQ_RELEASE, 8'd5,  16'h0055, 16'h0066, 1'b0, 1'b1, 16'd100,  t0 + 30);
        push_req(REQ_PRESS,   8'd5,  16'h0055, 16'h0066, 1'b1, 1'b0, 16'h0000, t0 + 31);
        push_req(REQ_PRESS,   8'd5,  16'h0057, 16'h0068, 1'b0, 1'b0, 16'h0000, t0 + 32);
        // two releases expire on one tick; emulated release leaves the store alone
        push_req(REQ_RELEASE, 8'd1,  16'h0001, 16'h0002, 1'b0, 1'b1, 16'd9,    t0 + 40);
        push_req(REQ_RELEASE, 8'd2,  16'h0003, 16'h0004, 1'b0, 1'b1, 16'd9,    t0 + 41);
        push_req(REQ_RELEASE, 8'd1,  16'h7777, 16'h7777, 1'b1, 1'b1, 16'd9,    t0 + 42);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, t0 + 100);
        // signed difference of exactly 2^31 is not yet expired
        push_req(REQ_RELEASE, 8'd4,  16'h8001, 16'h7FFE, 1'b0, 1'b1, 16'd9,    32'h0);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 32'h8000_0014);
        push_req(REQ_TICK,    8'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 32'h8000_0013);
        wait_drained();

        write_reg(CFG_DEBOUNCE, 16'd100);
        write_reg(CFG_THRESHOLD, 16'd4);
        random_phase(45, $urandom);
        wait_drained();

        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_THRESHOLD, 16'd0);
        random_phase(40, 32'hFFFF_FF00);
        wait_drained();

        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        random_phase(30, $urandom);
        wait_drained();

        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd0);
        random_phase(30, $urandom);
        wait_drained();

        // no idling on either side for this stretch
        write_reg(CFG_DEBOUNCE, 16'd37);
        write_reg(CFG_THRESHOLD, 16'd1000);
        calm = 1'b1;
        random_phase(45, $urandom);
        wait_drained();
        calm = 1'b0;

        write_reg(CFG_DEBOUNCE, 16'd5);
        write_reg(CFG_THRESHOLD, 16'd0);
        random_phase(50, $urandom);
        wait_drained();

        if (errors == 0 && expected_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
